// ===== design/ttce_pkg.sv =====
// Shared types, codes and defaults for the text terminal cursor engine.
// Depends on nothing; every other design file except ttce_ram imports it.
package ttce_pkg;

	localparam int SCREEN_WIDTH_DEF  = 80;
	localparam int SCREEN_HEIGHT_DEF = 25;
	localparam int TAB_SPACES_DEF    = 4;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam logic [7:0] TEXT_ATTR_RESET   = 8'h0F;
	localparam logic [7:0] CURSOR_ATTR_RESET = 8'hF0;

	localparam logic CFG_TEXT_ATTR   = 1'b0;
	localparam logic CFG_CURSOR_ATTR = 1'b1;

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_TAB,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
	} in_item_t;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
		logic        addr_ok;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	typedef struct packed {
		logic pop;
		logic init_busy;
	} back_status_t;

endpackage

// ===== design/ttce_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ttce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ttce_front.sv =====
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on ttce_pkg.
module ttce_front import ttce_pkg::*; #(
	parameter int CELL_COUNT = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  in_item_t     in_item,
	input  back_status_t status,
	output cmd_head_t    head
);

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cmd_new;
	logic       push;
	logic       pop;

	assign in_stall = (count_q == 2'd2) || status.init_busy;
	assign push     = in_valid && !in_stall;
	assign pop      = status.pop;

	always_comb begin
		cmd_new.char_code    = in_item.char_code;
		cmd_new.cell_address = in_item.cell_address;
		cmd_new.addr_ok      = 32'(in_item.cell_address) < 32'(CELL_COUNT);
		case (in_item.kind)
			KIND_PUT: begin
				case (in_item.char_code)
					CH_NEWLINE:   cmd_new.op = OP_NEWLINE;
					CH_BACKSPACE: cmd_new.op = OP_BACKSPACE;
					CH_TAB:       cmd_new.op = OP_TAB;
					default:      cmd_new.op = OP_PRINT;
				endcase
			end
			KIND_CLEAR: cmd_new.op = OP_CLEAR;
			KIND_READ:  cmd_new.op = OP_READ;
			default:    cmd_new.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head.valid = count_q != 2'd0;
	assign head.cmd   = q_mem_q[rd_ptr_q];

endmodule

// ===== design/ttce_back.sv =====
// Back end: sequencer that carries out queued commands on the cell store,
// holds the cursor, the attribute registers and the result register.
// Depends on ttce_pkg and ttce_ram.
module ttce_back import ttce_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TAB_SPACES    = TAB_SPACES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_head_t    head,
	output back_status_t status,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_wdata,
	output logic         out_valid,
	input  logic         out_stall,
	output out_item_t    out_item
);

	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int MOVE  = CELLS - SCREEN_WIDTH;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(SCREEN_WIDTH);
	localparam int RW    = $clog2(SCREEN_HEIGHT);
	localparam int SW    = $clog2(CELLS + 1);
	localparam int TW    = $clog2(TAB_SPACES + 1);

	typedef enum logic [13:0] {
		ST_INIT      = 14'b00000000000001,
		ST_IDLE      = 14'b00000000000010,
		ST_PRINT     = 14'b00000000000100,
		ST_NEWLINE   = 14'b00000000001000,
		ST_BS_ZERO   = 14'b00000000010000,
		ST_BS_STEP   = 14'b00000000100000,
		ST_BS_READ   = 14'b00000001000000,
		ST_BS_CHECK  = 14'b00000010000000,
		ST_SCROLL    = 14'b00000100000000,
		ST_CURSOR    = 14'b00001000000000,
		ST_CLEAR     = 14'b00010000000000,
		ST_READ      = 14'b00100000000000,
		ST_READ_DATA = 14'b01000000000000,
		ST_RESP      = 14'b10000000000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [SW-1:0]   sc_q;
	logic [TW-1:0]   rem_q;
	logic [7:0]      char_q;
	logic [15:0]     data_q;
	logic [AW-1:0]   addr_q;
	logic            addr_ok_q;
	logic [7:0]      tattr_q;
	logic [7:0]      cattr_q;
	logic            out_valid_q;
	out_item_t       out_item_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [15:0]     ram_rdata;
	logic [AW-1:0]   idx;
	logic [SW-1:0]   sc_src;
	logic [SW-1:0]   sc_dst;
	logic            resp_load;
	logic [31:0]     idx_wide;
	logic [31:0]     addr_wide;

	assign idx_wide  = 32'(row_q) * 32'(SCREEN_WIDTH) + 32'(col_q);
	assign idx       = idx_wide[AW-1:0];
	assign addr_wide = 32'(head.cmd.cell_address);
	assign sc_src    = sc_q + SW'(SCREEN_WIDTH);
	assign sc_dst    = sc_q - SW'(1);
	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	assign status.pop       = (state_q == ST_IDLE) && head.valid;
	assign status.init_busy = state_q == ST_INIT;

	// Store access: one write and one read address each cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx;
		ram_wdata = 16'h0000;
		ram_raddr = idx;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = sc_q[AW-1:0];
			end
			ST_PRINT: begin
				ram_we    = 1'b1;
				ram_wdata = {tattr_q, char_q};
			end
			ST_NEWLINE, ST_BS_ZERO: begin
				ram_we = 1'b1;
			end
			ST_SCROLL: begin
				// Reads run one cell ahead of the writes; the bottom row fills with zero.
				ram_raddr = (sc_q < SW'(MOVE)) ? sc_src[AW-1:0] : '0;
				ram_we    = sc_q != '0;
				ram_waddr = sc_dst[AW-1:0];
				ram_wdata = (sc_dst < SW'(MOVE)) ? ram_rdata : 16'h0000;
			end
			ST_CURSOR: begin
				ram_we    = 1'b1;
				ram_wdata = {cattr_q, 8'h00};
			end
			ST_READ: begin
				ram_raddr = addr_q;
			end
			default: begin
			end
		endcase
	end

	ttce_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			data_q    <= 16'h0000;
			char_q    <= (head.cmd.op == OP_TAB) ? CH_SPACE : head.cmd.char_code;
			addr_q    <= addr_wide[AW-1:0];
			addr_ok_q <= head.cmd.addr_ok;
		end else if (state_q == ST_READ_DATA) begin
			data_q <= addr_ok_q ? ram_rdata : 16'h0000;
		end
		if (resp_load) begin
			out_item_q <= {data_q, 7'(col_q), 5'(row_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			sc_q        <= '0;
			rem_q       <= '0;
			tattr_q     <= TEXT_ATTR_RESET;
			cattr_q     <= CURSOR_ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TEXT_ATTR: tattr_q <= cfg_wdata;
					default:       cattr_q <= cfg_wdata;
				endcase
			end

			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					sc_q <= sc_q + SW'(1);
					if (sc_q == SW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						rem_q <= '0;
						case (head.cmd.op)
							OP_PRINT: begin
								rem_q   <= TW'(1);
								state_q <= ST_PRINT;
							end
							OP_TAB: begin
								rem_q   <= TW'(TAB_SPACES);
								state_q <= ST_PRINT;
							end
							OP_NEWLINE:   state_q <= ST_NEWLINE;
							OP_BACKSPACE: state_q <= ST_BS_ZERO;
							OP_CLEAR: begin
								sc_q    <= '0;
								state_q <= ST_CLEAR;
							end
							OP_READ: state_q <= ST_READ;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_PRINT: begin
					rem_q <= rem_q - TW'(1);
					if (col_q == CW'(SCREEN_WIDTH - 1)) begin
						col_q <= '0;
						if (row_q == RW'(SCREEN_HEIGHT - 1)) begin
							sc_q    <= '0;
							state_q <= ST_SCROLL;
						end else begin
							row_q   <= row_q + RW'(1);
							state_q <= (rem_q == TW'(1)) ? ST_CURSOR : ST_PRINT;
						end
					end else begin
						col_q   <= col_q + CW'(1);
						state_q <= (rem_q == TW'(1)) ? ST_CURSOR : ST_PRINT;
					end
				end
				ST_NEWLINE: begin
					col_q <= '0;
					if (row_q == RW'(SCREEN_HEIGHT - 1)) begin
						sc_q    <= '0;
						state_q <= ST_SCROLL;
					end else begin
						row_q   <= row_q + RW'(1);
						state_q <= ST_CURSOR;
					end
				end
				ST_SCROLL: begin
					sc_q <= sc_q + SW'(1);
					if (sc_q == SW'(CELLS)) begin
						state_q <= (rem_q != '0) ? ST_PRINT : ST_CURSOR;
					end
				end
				ST_BS_ZERO: state_q <= ST_BS_STEP;
				ST_BS_STEP: begin
					if (col_q == '0 && row_q == '0) begin
						state_q <= ST_CURSOR;
					end else begin
						if (col_q != '0) begin
							col_q <= col_q - CW'(1);
						end else begin
							row_q <= row_q - RW'(1);
							col_q <= CW'(SCREEN_WIDTH - 1);
						end
						state_q <= ST_BS_READ;
					end
				end
				ST_BS_READ:  state_q <= ST_BS_CHECK;
				ST_BS_CHECK: state_q <= (ram_rdata == 16'h0000) ? ST_BS_STEP : ST_CURSOR;
				ST_CURSOR:   state_q <= ST_RESP;
				ST_CLEAR: begin
					sc_q <= sc_q + SW'(1);
					if (sc_q == SW'(CELLS - 1)) begin
						col_q   <= '0;
						row_q   <= '0;
						state_q <= ST_RESP;
					end
				end
				ST_READ:      state_q <= ST_READ_DATA;
				ST_READ_DATA: state_q <= ST_RESP;
				ST_RESP: begin
					if (resp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(SCREEN_HEIGHT - 1) && col_q <= CW'(SCREEN_WIDTH - 1))
		else $error("cursor left the screen");
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RESP)
		else $error("result raised outside the response step");
	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && $past(state_q) == ST_CLEAR) |-> (col_q == '0 && row_q == '0))
		else $error("clear did not home the cursor");
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_SCROLL && state_q != ST_SCROLL)
		|-> row_q == RW'(SCREEN_HEIGHT - 1))
		else $error("scroll ended off the bottom row");
`endif

endmodule

// ===== design/text_terminal_cursor_engine_top.sv =====
// A backspace steps back over each empty cell in turn; a scroll moves the store and a
// clear zeroes it cell by cell, both through the single write port of the cell store.
// Throughput: one request at a time in the back end, a two-entry queue absorbs bursts.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the store while
// no request is accepted (configuration writes are still taken).
module text_terminal_cursor_engine_top import ttce_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TAB_SPACES    = TAB_SPACES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	// The front end decodes each request into a command; the back end pops one
	// command at a time and reports its status (pop, clearing pass) back.
	cmd_head_t    head;
	back_status_t status;

	ttce_front #(
		.CELL_COUNT(SCREEN_WIDTH * SCREEN_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.status  (status),
		.head    (head)
	);

	// The back end owns the cell store, the cursor and the result register, so a
	// finished result can wait for the consumer while the queue keeps filling.
	ttce_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.TAB_SPACES   (TAB_SPACES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the text terminal cursor engine: a queue-fed driver,
// a checking monitor and a cell-level screen predictor. Depends on ttce_pkg and
// text_terminal_cursor_engine_top.
`timescale 1ns / 100ps

module tb;
	import ttce_pkg::*;

	localparam int COLS = SCREEN_WIDTH_DEF;
	localparam int ROWS = SCREEN_HEIGHT_DEF;
	localparam int TABS = TAB_SPACES_DEF;
	localparam int CELLS = COLS * ROWS;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// Neither side takes a random break inside this window of cycles.
	localparam int CALM_FROM = 4000;
	localparam int CALM_TO = 10000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_wdata;

	// Predictor state: a private copy of the screen, cursor and attributes.
	logic [15:0] screen [CELLS];
	int cur_col;
	int cur_row;
	logic [7:0] text_attr;
	logic [7:0] cursor_attr;

	in_item_t pending_requests[$];
	out_item_t expected_results[$];
	int mismatches = 0;
	int cycle_count;

	text_terminal_cursor_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run, scrolls, clears and long
	// backspace walks included.
	initial begin
		#300_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic bit take_break();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
		return $urandom_range(99) < 14;
	endfunction

	function automatic int cursor_cell();
		int idx;
		idx = cur_row * COLS + cur_col;
		return (idx < CELLS) ? idx : 0;
	endfunction

	// Scrolling happens the moment the row would move past the bottom edge.
	task automatic advance_row();
		cur_row++;
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
			cur_row = ROWS - 1;
		end
	endtask

	task automatic print_char(logic [7:0] ch);
		screen[cursor_cell()] = {text_attr, ch};
		cur_col++;
		if (cur_col >= COLS) begin
			cur_col = 0;
			advance_row();
		end
	endtask

	// Backspace walks back over empty cells to the last written one or home.
	task automatic erase_back();
		int steps;
		steps = 0;
		screen[cursor_cell()] = '0;
		do begin
			if (cur_col > 0) cur_col--;
			else if (cur_row > 0) begin
				cur_row--;
				cur_col = COLS - 1;
			end else break;
			steps++;
		end while (screen[cursor_cell()] == 16'd0 && steps <= CELLS);
		screen[cursor_cell()] = '0;
	endtask

	task automatic predict_terminal(in_item_t req);
		out_item_t res;
		res = '0;
		case (req.kind)
			KIND_PUT: begin
				if (req.char_code == CH_NEWLINE) begin
					screen[cursor_cell()] = '0;
					cur_col = 0;
					advance_row();
				end else if (req.char_code == CH_BACKSPACE) begin
					erase_back();
				end else if (req.char_code == CH_TAB) begin
					for (int i = 0; i < TABS; i++) print_char(CH_SPACE);
				end else begin
					print_char(req.char_code);
				end
				screen[cursor_cell()] = {cursor_attr, 8'h00};
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++) screen[i] = '0;
				cur_col = 0;
				cur_row = 0;
			end
			KIND_READ: begin
				if (req.cell_address < CELLS) res.cell_data = screen[req.cell_address];
			end
			default: ;
		endcase
		res.cursor_column = cur_col[6:0];
		res.cursor_row = cur_row[4:0];
		expected_results.push_back(res);
	endtask

	// Driver: a request leaves when accepted, and the next one goes out unless we idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			out_stall <= 1'b0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			out_stall <= take_break();
			if (in_valid && !in_stall) predict_terminal(in_item);
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					in_item <= pending_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result %h", out_item);
			end else begin
				want = expected_results.pop_front();
				if (out_item.cell_data !== want.cell_data
						|| out_item.cursor_column !== want.cursor_column
						|| out_item.cursor_row !== want.cursor_row) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mismatch data %h/%h col %0d/%0d row %0d/%0d (exp/got)",
							want.cell_data, out_item.cell_data,
							want.cursor_column, out_item.cursor_column,
							want.cursor_row, out_item.cursor_row);
				end
			end
		end
	end

	function automatic in_item_t make_request(logic [1:0] kind, logic [7:0] ch,
			logic [10:0] addr);
		in_item_t r;
		r.kind = kind;
		r.char_code = ch;
		r.cell_address = addr;
		return r;
	endfunction

	task automatic queue_random(int count);
		int roll;
		logic [7:0] ch;
		logic [10:0] addr;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			ch = 8'($urandom_range(255));
			addr = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
				: 11'($urandom_range(CELLS - 1));
			if (roll < 58) pending_requests.push_back(make_request(KIND_PUT, ch, addr));
			else if (roll < 63)
				pending_requests.push_back(make_request(KIND_PUT, CH_NEWLINE, addr));
			else if (roll < 70)
				pending_requests.push_back(make_request(KIND_PUT, CH_BACKSPACE, addr));
			else if (roll < 74)
				pending_requests.push_back(make_request(KIND_PUT, CH_TAB, addr));
			else if (roll < 75) pending_requests.push_back(make_request(KIND_CLEAR, ch, addr));
			else if (roll < 98) pending_requests.push_back(make_request(KIND_READ, ch, addr));
			else pending_requests.push_back(make_request(KIND_UNUSED, ch, addr));
		end
	endtask

	// The register changes only land while nothing is in flight.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_attributes(logic [7:0] text_value, logic [7:0] cursor_value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TEXT_ATTR;
		cfg_wdata <= text_value;
		@(posedge clk);
		cfg_index <= CFG_CURSOR_ATTR;
		cfg_wdata <= cursor_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		text_attr = text_value;
		cursor_attr = cursor_value;
	endtask

	initial begin
		cur_col = 0;
		cur_row = 0;
		text_attr = TEXT_ATTR_RESET;
		cursor_attr = CURSOR_ATTR_RESET;
		for (int i = 0; i < CELLS; i++) screen[i] = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TEXT_ATTR;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: reset attributes first, then the extremes.
		pending_requests.push_back(make_request(KIND_PUT, CH_BACKSPACE, 11'd0));
		pending_requests.push_back(make_request(KIND_PUT, 8'h41, 11'd0));
		pending_requests.push_back(make_request(KIND_PUT, 8'h00, 11'd0));
		pending_requests.push_back(make_request(KIND_PUT, 8'hFF, 11'd0));
		pending_requests.push_back(make_request(KIND_PUT, CH_TAB, 11'd0));
		pending_requests.push_back(make_request(KIND_READ, 8'h00, 11'd0));
		pending_requests.push_back(make_request(KIND_READ, 8'h00, 11'd3));
		pending_requests.push_back(make_request(KIND_PUT, CH_NEWLINE, 11'd0));
		pending_requests.push_back(make_request(KIND_PUT, CH_NEWLINE, 11'd0));
		// Backspace across empty rows back to the last written cell.
		pending_requests.push_back(make_request(KIND_PUT, CH_BACKSPACE, 11'd0));
		pending_requests.push_back(make_request(KIND_READ, 8'h00, 11'd6));
		pending_requests.push_back(make_request(KIND_READ, 8'h00, 11'(CELLS - 1)));
		pending_requests.push_back(make_request(KIND_READ, 8'h00, 11'(CELLS)));
		pending_requests.push_back(make_request(KIND_READ, 8'hFF, 11'h7FF));
		pending_requests.push_back(make_request(KIND_UNUSED, 8'hFF, 11'h7FF));
		pending_requests.push_back(make_request(KIND_CLEAR, 8'h00, 11'd0));
		pending_requests.push_back(make_request(KIND_READ, 8'h00, 11'd0));
		wait_drained();

		write_attributes(8'h00, 8'hFF);
		queue_random(210);
		wait_drained();
		write_attributes(8'hFF, 8'h00);
		queue_random(210);
		wait_drained();
		write_attributes(8'($urandom_range(255)), 8'($urandom_range(255)));
		queue_random(210);
		wait_drained();
		write_attributes(TEXT_ATTR_RESET, CURSOR_ATTR_RESET);
		queue_random(210);
		wait_drained();

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
